// ----- src/rcsa_pkg.sv -----
// ----------------------------------------------------------------------------
// rcsa_pkg
// Shared types and constants for the reference-counted slot allocator.
// ----------------------------------------------------------------------------
package rcsa_pkg;

  localparam int SLOT_COUNT = 256;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int DEPTH_W    = SLOT_W + 1;
  localparam int HANDLE_W   = 32;
  localparam int COUNT_W    = 16;

  localparam logic [DEPTH_W-1:0] SLOT_LIMIT = DEPTH_W'(SLOT_COUNT);

  localparam logic signed [COUNT_W-1:0] COUNT_MAX = {1'b0, {(COUNT_W-1){1'b1}}};
  localparam logic signed [COUNT_W-1:0] COUNT_MIN = {1'b1, {(COUNT_W-1){1'b0}}};

  typedef enum logic [0:0] {
    OP_ALLOC  = 1'b0,
    OP_ADJUST = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_UNALLOC = 2'd2
  } status_t;

  // Free stack requests from the execute stage
  typedef struct packed {
    logic              push;
    logic              pop;
    logic [SLOT_W-1:0] push_slot;
  } stack_ctrl_t;

  // Free stack view seen by the execute stage
  typedef struct packed {
    logic              empty;
    logic [SLOT_W-1:0] top;
  } stack_stat_t;

  // Slot table update from the execute stage
  typedef struct packed {
    logic                       wr_en;
    logic                       wr_handle;
    logic                       used;
    logic [SLOT_W-1:0]          addr;
    logic signed [COUNT_W-1:0]  count;
    logic [HANDLE_W-1:0]        handle;
  } table_wr_t;

endpackage

// ----- src/refcount_slot_allocator_core.sv -----
// ----------------------------------------------------------------------------
// refcount_slot_allocator_core
// Reference-counted slot allocator with a LIFO free list.
// ----------------------------------------------------------------------------
// The block takes one item per clock when the output side is ready and
// returns one result per item via the execute stage and output register. An
// item is registered on transfer while its slot count is read from the count
// memory; a single execute stage then checks the in-use flag, adds and
// saturates the count, pops or pushes the free stack, and writes the table.
// A table write is forwarded to an item read on the same edge, and the free
// stack keeps its top entries in registers, so that execute stage sets the
// rate of one item per cycle. The output register holds a result while the
// consumer stalls, and the block stops taking items only when both the output
// register and the execute stage are full. No clearing pass is needed after
// reset: in-use flags clear at once, and counts, handles and stack entries are
// only read after they have been written.
// ----------------------------------------------------------------------------
module refcount_slot_allocator_core
  import rcsa_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      operation,
  input  logic [HANDLE_W-1:0]       entry_handle,
  input  logic signed [COUNT_W-1:0] initial_count,
  input  logic [SLOT_W-1:0]         slot_index,
  input  logic signed [COUNT_W-1:0] delta,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [SLOT_W-1:0]         slot_id,
  output logic signed [COUNT_W-1:0] new_count,
  output logic                      freed,
  output logic [1:0]                status
);

  // Execute stage registers
  logic                      s1_valid;
  op_t                       s1_op;
  logic [HANDLE_W-1:0]       s1_handle;
  logic signed [COUNT_W-1:0] s1_amount;
  logic [SLOT_W-1:0]         s1_idx;

  logic [DEPTH_W-1:0]        high_water;
  logic                      hw_inc;

  logic                      in_xfer;
  logic                      e_fire;

  stack_ctrl_t               stk_ctrl;
  stack_stat_t               stk_stat;
  table_wr_t                 tbl_wr;
  logic                      tbl_used;
  logic signed [COUNT_W-1:0] tbl_count;

  logic signed [COUNT_W:0]   sum;
  logic signed [COUNT_W-1:0] sat;
  logic [SLOT_W-1:0]         res_slot;
  logic signed [COUNT_W-1:0] res_count;
  logic                      res_freed;
  status_t                   res_status;

  assign e_fire   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || e_fire;
  assign in_xfer  = in_valid && in_ready;

  // Load the execute stage on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_xfer) begin
      s1_valid <= 1'b1;
    end else if (e_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_op     <= op_t'(operation);
      s1_handle <= entry_handle;
      s1_amount <= (op_t'(operation) == OP_ALLOC) ? initial_count : delta;
      s1_idx    <= slot_index;
    end
  end

  rcsa_slot_table u_table (
    .clk         (clk),
    .rst         (rst),
    .rd_en       (in_xfer),
    .rd_addr     (slot_index),
    .wr          (tbl_wr),
    .used        (tbl_used),
    .count       (tbl_count)
  );

  rcsa_free_stack u_stack (
    .clk  (clk),
    .rst  (rst),
    .ctrl (stk_ctrl),
    .stat (stk_stat)
  );

  // Add and saturate the adjusted count
  assign sum = {tbl_count[COUNT_W-1], tbl_count} + {s1_amount[COUNT_W-1], s1_amount};

  always_comb begin
    if (sum[COUNT_W] != sum[COUNT_W-1]) begin
      sat = sum[COUNT_W] ? COUNT_MIN : COUNT_MAX;
    end else begin
      sat = sum[COUNT_W-1:0];
    end
  end

  // Execute one item
  always_comb begin
    res_slot   = '0;
    res_count  = '0;
    res_freed  = 1'b0;
    res_status = ST_OK;
    stk_ctrl   = '0;
    tbl_wr     = '0;
    hw_inc     = 1'b0;
    tbl_wr.handle = s1_handle;
    unique case (s1_op)
      OP_ALLOC: begin
        if (!stk_stat.empty) begin
          res_slot     = stk_stat.top;
          stk_ctrl.pop = e_fire;
        end else if (high_water != SLOT_LIMIT) begin
          res_slot = high_water[SLOT_W-1:0];
          hw_inc   = e_fire;
        end else begin
          res_status = ST_FULL;
        end
        if (res_status == ST_OK) begin
          res_count        = s1_amount;
          tbl_wr.wr_en     = e_fire;
          tbl_wr.wr_handle = 1'b1;
          tbl_wr.used      = 1'b1;
          tbl_wr.addr      = res_slot;
          tbl_wr.count     = s1_amount;
        end
      end
      OP_ADJUST: begin
        res_slot = s1_idx;
        if (!tbl_used) begin
          res_status = ST_UNALLOC;
        end else begin
          res_count          = sat;
          res_freed          = sat[COUNT_W-1] || (sat == '0);
          tbl_wr.wr_en       = e_fire;
          tbl_wr.used        = !res_freed;
          tbl_wr.addr        = s1_idx;
          tbl_wr.count       = sat;
          stk_ctrl.push      = e_fire && res_freed;
          stk_ctrl.push_slot = s1_idx;
        end
      end
    endcase
  end

  // Advance the high-water mark
  always_ff @(posedge clk) begin
    if (rst) begin
      high_water <= '0;
    end else if (hw_inc) begin
      high_water <= high_water + 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (e_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (e_fire) begin
      slot_id   <= res_slot;
      new_count <= res_count;
      freed     <= res_freed;
      status    <= res_status;
    end
  end

endmodule

// ----- src/rcsa_free_stack.sv -----
// ----------------------------------------------------------------------------
// rcsa_free_stack
// LIFO of freed slot numbers. The top two entries live in registers and the
// third one is prefetched from the memory every cycle, so a push or a pop can
// happen on every clock.
// ----------------------------------------------------------------------------
module rcsa_free_stack
  import rcsa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  stack_ctrl_t ctrl,
  output stack_stat_t stat
);

  logic [SLOT_W-1:0]  mem [SLOT_COUNT];
  logic [DEPTH_W-1:0] depth;
  logic [DEPTH_W-1:0] depth_next;
  logic [DEPTH_W-1:0] rd_ptr;
  logic [SLOT_W-1:0]  top0;
  logic [SLOT_W-1:0]  top1;
  logic [SLOT_W-1:0]  rd_data;
  logic               push_ok;
  logic               pop_ok;

  // Qualify requests against the current fill
  assign push_ok = ctrl.push && (depth != SLOT_LIMIT);
  assign pop_ok  = ctrl.pop && (depth != '0);

  always_comb begin
    depth_next = depth;
    if (push_ok) begin
      depth_next = depth + 1'b1;
    end else if (pop_ok) begin
      depth_next = depth - 1'b1;
    end
  end

  // Prefetch the third entry from the next top
  assign rd_ptr = depth_next - DEPTH_W'(3);

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
    end else begin
      depth <= depth_next;
    end
  end

  // Memory holds every pushed entry; read is registered
  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[depth[SLOT_W-1:0]] <= ctrl.push_slot;
    end
    rd_data <= mem[rd_ptr[SLOT_W-1:0]];
  end

  // Shift the cached top entries
  always_ff @(posedge clk) begin
    if (push_ok) begin
      top0 <= ctrl.push_slot;
      top1 <= top0;
    end else if (pop_ok) begin
      top0 <= top1;
      top1 <= rd_data;
    end
  end

  assign stat.empty = (depth == '0);
  assign stat.top   = top0;

endmodule

// ----- src/rcsa_slot_table.sv -----
// ----------------------------------------------------------------------------
// rcsa_slot_table
// Per-slot in-use flags, reference counts and handles. The flag and the count
// are read at transfer time and a write landing on the same edge is forwarded.
// ----------------------------------------------------------------------------
module rcsa_slot_table
  import rcsa_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      rd_en,
  input  logic [SLOT_W-1:0]         rd_addr,
  input  table_wr_t                 wr,
  output logic                      used,
  output logic signed [COUNT_W-1:0] count
);

  logic [SLOT_COUNT-1:0]      slot_used;
  logic signed [COUNT_W-1:0]  count_mem [SLOT_COUNT];
  logic [HANDLE_W-1:0]        handle_mem [SLOT_COUNT];
  logic signed [COUNT_W-1:0]  ram_q;
  logic                       used_q;
  logic signed [COUNT_W-1:0]  fwd_data;
  logic                       fwd_used;
  logic                       fwd_hit;

  // In-use flags, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_used <= '0;
    end else if (wr.wr_en) begin
      slot_used[wr.addr] <= wr.used;
    end
  end

  // Registered read of the in-use flag
  always_ff @(posedge clk) begin
    if (rd_en) begin
      used_q <= slot_used[rd_addr];
    end
  end

  // Count memory with registered read
  always_ff @(posedge clk) begin
    if (wr.wr_en) begin
      count_mem[wr.addr] <= wr.count;
    end
    if (rd_en) begin
      ram_q <= count_mem[rd_addr];
    end
  end

  // Handle memory
  always_ff @(posedge clk) begin
    if (wr.wr_en && wr.wr_handle) begin
      handle_mem[wr.addr] <= wr.handle;
    end
  end

  // Capture a same-edge write to the slot being read
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (rd_en) begin
      fwd_hit <= wr.wr_en && (wr.addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_data <= wr.count;
      fwd_used <= wr.used;
    end
  end

  assign used  = fwd_hit ? fwd_used : used_q;
  assign count = fwd_hit ? fwd_data : ram_q;

endmodule

// ----- src/rcsa_checker.sv -----
// ----------------------------------------------------------------------------
// rcsa_checker
// Port-level checks for the slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
module rcsa_checker
  import rcsa_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [SLOT_W-1:0]         slot_id,
  input logic signed [COUNT_W-1:0] new_count,
  input logic                      freed,
  input logic [1:0]                status
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(slot_id) && $stable(new_count)
      && $stable(freed) && $stable(status))
    else $error("result changed while stalled");

  // With the output register empty, input is always taken
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // A full table reports a cleared result
  a_full_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_FULL) |-> (slot_id == '0) && (new_count == '0) && !freed)
    else $error("table full result not cleared");

  // Release only happens on a successful adjust to a count below one
  a_freed_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && freed |-> (status == ST_OK) && (new_count[COUNT_W-1] || (new_count == '0)))
    else $error("slot released with positive count");

  // An unallocated adjust leaves count zero and releases nothing
  a_unalloc_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_UNALLOC) |-> (new_count == '0) && !freed)
    else $error("bad unallocated adjust result");

endmodule

bind refcount_slot_allocator_core rcsa_checker u_rcsa_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .slot_id   (slot_id),
  .new_count (new_count),
  .freed     (freed),
  .status    (status)
);

// ----- bench/tb_refcount_slot_allocator_core.sv -----
// ----------------------------------------------------------------------------
// tb_refcount_slot_allocator_core
// Self-checking bench for the reference-counted slot allocator.
// ----------------------------------------------------------------------------
// A queue of allocate and adjust items is built up front. It starts with a
// short directed run: saturation at both count limits, free on zero and on
// negative counts, LIFO reuse of freed slots and adjusts of unused slots.
// Random items follow in four idling phases: a fill phase that runs the table
// full, two churn phases and a drain phase. A table model predicts each result
// when its input transfer happens. The monitor compares every output transfer
// against the oldest prediction. Early on, the consumer holds off for a long
// stretch so the block backs up into its input.
// ----------------------------------------------------------------------------
module tb_refcount_slot_allocator_core;
  import rcsa_pkg::*;

  localparam int PH_NO_IDLE    = 0;
  localparam int PH_SEND_IDLE  = 1;
  localparam int PH_RECV_STALL = 2;
  localparam int PH_BOTH_IDLE  = 3;

  // Table copies: one steers stimulus generation, one predicts results
  localparam int GEN_COPY = 0;
  localparam int CHK_COPY = 1;

  localparam int PHASE_ITEMS  = 310;
  localparam int HOLD_AT      = 40;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 100000;

  typedef struct packed {
    op_t                       op;
    logic [HANDLE_W-1:0]       handle;
    logic signed [COUNT_W-1:0] init_cnt;
    logic [SLOT_W-1:0]         slot;
    logic signed [COUNT_W-1:0] delta;
    logic [1:0]                phase;
  } alloc_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0]         slot;
    logic signed [COUNT_W-1:0] count;
    logic                      freed;
    status_t                   status;
  } alloc_result_t;

  logic                      clk;
  logic                      rst           = 1'b1;
  logic                      in_valid      = 1'b0;
  logic                      in_ready;
  logic                      operation     = 1'b0;
  logic [HANDLE_W-1:0]       entry_handle  = '0;
  logic signed [COUNT_W-1:0] initial_count = '0;
  logic [SLOT_W-1:0]         slot_index    = '0;
  logic signed [COUNT_W-1:0] delta         = '0;
  logic                      out_valid;
  logic                      out_ready     = 1'b0;
  logic [SLOT_W-1:0]         slot_id;
  logic signed [COUNT_W-1:0] new_count;
  logic                      freed;
  logic [1:0]                status;

  alloc_item_t   stim_q[$];
  alloc_result_t expect_q[$];

  logic                      tbl_used  [2][SLOT_COUNT];
  logic signed [COUNT_W-1:0] tbl_count [2][SLOT_COUNT];
  logic [SLOT_W-1:0]         tbl_stack [2][SLOT_COUNT];
  int                        tbl_depth [2];
  int                        tbl_high  [2];

  logic [1:0] cur_phase  = 2'(PH_NO_IDLE);
  int         fail_cnt   = 0;
  int         hold_wait  = 0;
  int         hold_left  = 0;
  int         cycle_cnt  = 0;

  refcount_slot_allocator_core dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .operation     (operation),
    .entry_handle  (entry_handle),
    .initial_count (initial_count),
    .slot_index    (slot_index),
    .delta         (delta),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .slot_id       (slot_id),
    .new_count     (new_count),
    .freed         (freed),
    .status        (status)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Apply one item to table copy k and return the result it produces
  function automatic alloc_result_t step_table(input int k, input alloc_item_t it);
    alloc_result_t             r;
    logic signed [COUNT_W:0]   sum;
    logic [SLOT_W-1:0]         s;
    r        = '0;
    r.status = ST_OK;
    if (it.op == OP_ALLOC) begin
      // pop the most recently freed slot, else take a fresh one
      if (tbl_depth[k] > 0) begin
        tbl_depth[k]--;
        s = tbl_stack[k][tbl_depth[k]];
      end else if (tbl_high[k] < SLOT_COUNT) begin
        s = SLOT_W'(tbl_high[k]);
        tbl_high[k]++;
      end else begin
        r.status = ST_FULL;
        return r;
      end
      tbl_used[k][s]  = 1'b1;
      tbl_count[k][s] = it.init_cnt;
      r.slot          = s;
      r.count         = it.init_cnt;
    end else begin
      r.slot = it.slot;
      if (!tbl_used[k][it.slot]) begin
        r.status = ST_UNALLOC;
        return r;
      end
      // add with one guard bit, saturate on overflow
      sum = {tbl_count[k][it.slot][COUNT_W-1], tbl_count[k][it.slot]} +
            {it.delta[COUNT_W-1], it.delta};
      if (sum[COUNT_W] != sum[COUNT_W-1]) begin
        r.count = sum[COUNT_W] ? COUNT_MIN : COUNT_MAX;
      end else begin
        r.count = sum[COUNT_W-1:0];
      end
      tbl_count[k][it.slot] = r.count;
      // release the slot once its count drops below one
      if (r.count[COUNT_W-1] || r.count == '0) begin
        tbl_used[k][it.slot] = 1'b0;
        if (tbl_depth[k] < SLOT_COUNT) begin
          tbl_stack[k][tbl_depth[k]] = it.slot;
          tbl_depth[k]++;
        end
        r.freed = 1'b1;
      end
    end
    return r;
  endfunction

  // Queue one item and advance the generation copy of the table
  function automatic void add_item(input op_t op, input logic [HANDLE_W-1:0] h,
                                   input logic signed [COUNT_W-1:0] c,
                                   input logic [SLOT_W-1:0] s,
                                   input logic signed [COUNT_W-1:0] d,
                                   input int ph);
    alloc_item_t it;
    it.op       = op;
    it.handle   = h;
    it.init_cnt = c;
    it.slot     = s;
    it.delta    = d;
    it.phase    = 2'(ph);
    void'(step_table(GEN_COPY, it));
    stim_q.push_back(it);
  endfunction

  // Build stimulus, run reset, wait for the last result
  initial begin
    int                        alloc_pct;
    int                        noise_pct;
    int                        pick;
    int                        roll;
    int                        start;
    int                        found;
    logic signed [COUNT_W-1:0] cnt;
    logic signed [COUNT_W-1:0] dlt;

    for (int k = 0; k < 2; k++) begin
      for (int i = 0; i < SLOT_COUNT; i++) tbl_used[k][i] = 1'b0;
      tbl_depth[k] = 0;
      tbl_high[k]  = 0;
    end

    // directed: unused slots, count limits, frees and LIFO reuse
    add_item(OP_ADJUST, $urandom(), COUNT_W'($urandom()), 8'd0, 16'sd5, PH_NO_IDLE);
    add_item(OP_ADJUST, $urandom(), COUNT_W'($urandom()), 8'd255, COUNT_MIN, PH_NO_IDLE);
    add_item(OP_ALLOC, '0, COUNT_MAX, SLOT_W'($urandom()), COUNT_W'($urandom()), PH_NO_IDLE);
    add_item(OP_ALLOC, '1, COUNT_MIN, SLOT_W'($urandom()), COUNT_W'($urandom()), PH_NO_IDLE);
    add_item(OP_ALLOC, $urandom(), 16'sd0, SLOT_W'($urandom()), COUNT_W'($urandom()),
             PH_NO_IDLE);
    add_item(OP_ALLOC, $urandom(), 16'sd1, SLOT_W'($urandom()), COUNT_W'($urandom()),
             PH_NO_IDLE);
    add_item(OP_ADJUST, $urandom(), COUNT_W'($urandom()), 8'd0, COUNT_MAX, PH_NO_IDLE);
    add_item(OP_ADJUST, $urandom(), COUNT_W'($urandom()), 8'd1, COUNT_MIN, PH_NO_IDLE);
    add_item(OP_ADJUST, $urandom(), COUNT_W'($urandom()), 8'd2, 16'sd0, PH_NO_IDLE);
    add_item(OP_ADJUST, $urandom(), COUNT_W'($urandom()), 8'd3, -16'sd1, PH_NO_IDLE);
    add_item(OP_ADJUST, $urandom(), COUNT_W'($urandom()), 8'd3, 16'sd1, PH_NO_IDLE);
    add_item(OP_ALLOC, $urandom(), 16'sd5, SLOT_W'($urandom()), COUNT_W'($urandom()),
             PH_NO_IDLE);
    add_item(OP_ALLOC, $urandom(), 16'sd2, SLOT_W'($urandom()), COUNT_W'($urandom()),
             PH_NO_IDLE);
    add_item(OP_ALLOC, $urandom(), 16'sd1, SLOT_W'($urandom()), COUNT_W'($urandom()),
             PH_NO_IDLE);
    add_item(OP_ALLOC, $urandom(), 16'sd1, SLOT_W'($urandom()), COUNT_W'($urandom()),
             PH_NO_IDLE);
    add_item(OP_ADJUST, $urandom(), COUNT_W'($urandom()), 8'd0, COUNT_MIN, PH_NO_IDLE);
    add_item(OP_ADJUST, $urandom(), COUNT_W'($urandom()), 8'd4, COUNT_MAX, PH_NO_IDLE);
    add_item(OP_ADJUST, $urandom(), COUNT_W'($urandom()), 8'd3, 16'sd1, PH_NO_IDLE);
    add_item(OP_ADJUST, $urandom(), COUNT_W'($urandom()), 8'd3, -16'sd6, PH_NO_IDLE);

    // random: fill to table full, churn twice, then drain
    for (int ph = PH_NO_IDLE; ph <= PH_BOTH_IDLE; ph++) begin
      alloc_pct = (ph == PH_NO_IDLE) ? 92 : (ph == PH_BOTH_IDLE) ? 15 : 35;
      noise_pct = (ph == PH_NO_IDLE) ? 0 : 15;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(99);
        roll = $urandom_range(99);
        if (pick < alloc_pct) begin
          if (ph == PH_NO_IDLE || roll < 70) begin
            cnt = COUNT_W'(1 + $urandom_range(3));
          end else if (roll < 85) begin
            cnt = COUNT_W'($urandom());
          end else begin
            case ($urandom_range(2))
              0:       cnt = COUNT_MAX;
              1:       cnt = COUNT_MIN;
              default: cnt = '0;
            endcase
          end
          add_item(OP_ALLOC, $urandom(), cnt, SLOT_W'($urandom()), COUNT_W'($urandom()),
                   ph);
        end else if (pick < alloc_pct + noise_pct) begin
          add_item(OP_ADJUST, $urandom(), COUNT_W'($urandom()), SLOT_W'($urandom()),
                   COUNT_W'($urandom()), ph);
        end else begin
          // aim at a live slot when there is one
          start = $urandom_range(SLOT_COUNT - 1);
          found = -1;
          for (int i = 0; i < SLOT_COUNT && found < 0; i++) begin
            if (tbl_used[GEN_COPY][(start + i) % SLOT_COUNT]) begin
              found = (start + i) % SLOT_COUNT;
            end
          end
          if (found < 0) found = start;
          if (ph == PH_NO_IDLE) begin
            dlt = COUNT_W'($urandom_range(3));
          end else if (ph == PH_BOTH_IDLE && roll < 80) begin
            dlt = COUNT_W'(-int'($urandom_range(4)));
          end else if (roll < 60) begin
            dlt = COUNT_W'(int'($urandom_range(3)) - 2);
          end else if (roll < 80) begin
            dlt = COUNT_W'($urandom());
          end else begin
            case ($urandom_range(3))
              0:       dlt = COUNT_MAX;
              1:       dlt = COUNT_MIN;
              2:       dlt = 16'sd1;
              default: dlt = -16'sd1;
            endcase
          end
          add_item(OP_ADJUST, $urandom(), COUNT_W'($urandom()), SLOT_W'(found), dlt, ph);
        end
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (stim_q.size() != 0 || expect_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Drive input items; predict each one on its transfer
  always @(posedge clk) begin : drive_items
    logic taken;
    int   idle_pct;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      taken = in_valid && in_ready;
      if (taken) begin
        expect_q.push_back(step_table(CHK_COPY, stim_q[0]));
        void'(stim_q.pop_front());
      end
      // hold the current item until transfer, then offer the next or idle
      if (!in_valid || taken) begin
        if (stim_q.size() != 0) begin
          idle_pct = (stim_q[0].phase == PH_SEND_IDLE) ? 60 :
                     (stim_q[0].phase == PH_BOTH_IDLE) ? 33 : 0;
          if (int'($urandom_range(99)) >= idle_pct) begin
            in_valid      <= 1'b1;
            operation     <= stim_q[0].op;
            entry_handle  <= stim_q[0].handle;
            initial_count <= stim_q[0].init_cnt;
            slot_index    <= stim_q[0].slot;
            delta         <= stim_q[0].delta;
            cur_phase     <= stim_q[0].phase;
          end else begin
            in_valid <= 1'b0;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // One long consumer hold-off early on to back the block up
  always @(posedge clk) begin : hold_off
    if (rst) begin
      hold_wait <= HOLD_AT;
      hold_left <= 0;
    end else if (hold_wait != 0) begin
      hold_wait <= hold_wait - 1;
      if (hold_wait == 1) begin
        hold_left <= HOLD_CYCLES;
      end
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Check each result transfer and pace the consumer side
  always @(posedge clk) begin : watch_results
    alloc_result_t want;
    int            stall_pct;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expect_q.size() == 0) begin
          $error("unexpected result: slot_id %0d new_count %0d status %0d",
                 slot_id, new_count, status);
          fail_cnt++;
        end else begin
          want = expect_q.pop_front();
          if (slot_id !== want.slot) begin
            $error("slot_id: expected %0d, got %0d", want.slot, slot_id);
            fail_cnt++;
          end
          if (new_count !== want.count) begin
            $error("new_count: expected %0d, got %0d", want.count, new_count);
            fail_cnt++;
          end
          if (freed !== want.freed) begin
            $error("freed: expected %0d, got %0d", want.freed, freed);
            fail_cnt++;
          end
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            fail_cnt++;
          end
        end
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
      end else begin
        stall_pct = (cur_phase == PH_RECV_STALL) ? 60 :
                    (cur_phase == PH_BOTH_IDLE) ? 33 : 0;
        out_ready <= (int'($urandom_range(99)) >= stall_pct);
      end
    end
  end

  // End a hung run
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule

// ----- sim.f -----
src/rcsa_pkg.sv
src/rcsa_free_stack.sv
src/rcsa_slot_table.sv
src/refcount_slot_allocator_core.sv
src/rcsa_checker.sv
bench/tb_refcount_slot_allocator_core.sv
